// ===== hw/rtl/ipv4dq_pkg.sv =====
// Package for the dotted-quad IPv4 parser: word types, parse state and
// character constants. No dependencies.
package ipv4dq_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] address;
        logic [3:0]  consumed;
        logic        status;
    } t_out_word;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DRAIN  = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  octet_index;
        logic [7:0]  octet_value;
        logic [1:0]  digit_count;
        logic        leading_zero;
        logic [23:0] packed_octets;
        logic [3:0]  byte_count;
    } t_parse_state;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [1:0]  LAST_OCTET = 2'd3;
    localparam logic [1:0]  MAX_DIGITS = 2'd3;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam t_parse_state PARSE_CLEAR = '{
        phase:         PH_START,
        octet_index:   2'd0,
        octet_value:   8'd0,
        digit_count:   2'd0,
        leading_zero:  1'b0,
        packed_octets: 24'd0,
        byte_count:    4'd0
    };

endpackage

// ===== hw/rtl/ipv4dq_in_reg.sv =====
// Input register of the dotted-quad parser: holds one word for the step logic.
// Depends on ipv4dq_pkg.
module ipv4dq_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ipv4dq_pkg::t_in_word i_word,
    output logic                o_valid,
    input  logic                i_take,
    output ipv4dq_pkg::t_in_word o_word
);

    logic                 r_valid;
    ipv4dq_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== hw/rtl/ipv4dq_step.sv =====
// Per-byte parse step: next parse state and the optional result word.
// Purely combinational. Depends on ipv4dq_pkg.
module ipv4dq_step (
    input  ipv4dq_pkg::t_parse_state i_state,
    input  ipv4dq_pkg::t_in_word     i_word,
    output ipv4dq_pkg::t_parse_state o_state,
    output logic                     o_emit,
    output ipv4dq_pkg::t_out_word    o_result
);

    logic [7:0]               ch;
    logic                     is_digit;
    logic [3:0]               dval;
    logic [11:0]              acc;
    logic                     fin;
    logic                     ok;
    ipv4dq_pkg::t_parse_state upd;

    assign ch       = i_word.byte_in;
    assign is_digit = (ch >= ipv4dq_pkg::CH_ZERO) && (ch <= ipv4dq_pkg::CH_NINE);
    assign dval     = 4'(ch - ipv4dq_pkg::CH_ZERO);
    // value * 10 + digit, as 8x + 2x + d
    assign acc      = {1'b0, i_state.octet_value, 3'b000}
                    + {3'b000, i_state.octet_value, 1'b0}
                    + {8'd0, dval};

    always_comb begin
        upd = i_state;
        fin = 1'b0;
        ok  = 1'b0;
        unique case (i_state.phase)
            ipv4dq_pkg::PH_START: begin
                if (!is_digit) begin
                    fin = 1'b1;
                end else begin
                    upd.octet_value  = {4'd0, dval};
                    upd.digit_count  = 2'd1;
                    upd.leading_zero = (dval == 4'd0);
                    upd.byte_count   = i_state.byte_count + 4'd1;
                    upd.phase        = ipv4dq_pkg::PH_DIGITS;
                    if (i_word.last) begin
                        fin = 1'b1;
                        ok  = (i_state.octet_index == ipv4dq_pkg::LAST_OCTET);
                    end
                end
            end
            ipv4dq_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    if (i_state.leading_zero
                        || (i_state.digit_count >= ipv4dq_pkg::MAX_DIGITS)
                        || (acc > ipv4dq_pkg::OCTET_MAX)) begin
                        fin = 1'b1;
                    end else begin
                        upd.octet_value = acc[7:0];
                        upd.digit_count = i_state.digit_count + 2'd1;
                        upd.byte_count  = i_state.byte_count + 4'd1;
                        if (i_word.last) begin
                            fin = 1'b1;
                            ok  = (i_state.octet_index == ipv4dq_pkg::LAST_OCTET);
                        end
                    end
                end else if (i_state.octet_index != ipv4dq_pkg::LAST_OCTET) begin
                    if (ch != ipv4dq_pkg::CH_DOT) begin
                        fin = 1'b1;
                    end else begin
                        upd.packed_octets = {i_state.packed_octets[15:0],
                                             i_state.octet_value};
                        upd.octet_value   = 8'd0;
                        upd.digit_count   = 2'd0;
                        upd.leading_zero  = 1'b0;
                        upd.octet_index   = i_state.octet_index + 2'd1;
                        upd.byte_count    = i_state.byte_count + 4'd1;
                        upd.phase         = ipv4dq_pkg::PH_START;
                        // a dot on the final byte leaves the address short
                        fin = i_word.last;
                    end
                end else begin
                    // terminator after the fourth octet, not consumed
                    fin = 1'b1;
                    ok  = (ch == ipv4dq_pkg::CH_SPACE) || (ch == ipv4dq_pkg::CH_NUL);
                end
            end
            default: begin
                if (i_word.last) begin
                    upd = ipv4dq_pkg::PARSE_CLEAR;
                end
            end
        endcase
    end

    always_comb begin
        o_emit = fin;
        if (ok) begin
            o_result.address  = {upd.packed_octets, upd.octet_value};
            o_result.consumed = upd.byte_count;
            o_result.status   = ipv4dq_pkg::ST_OK;
        end else begin
            o_result.address  = 32'd0;
            o_result.consumed = 4'd0;
            o_result.status   = ipv4dq_pkg::ST_ERR;
        end
        if (fin) begin
            o_state = ipv4dq_pkg::PARSE_CLEAR;
            // drain the rest of the buffer unless this was its final byte
            if (!i_word.last) begin
                o_state.phase = ipv4dq_pkg::PH_DRAIN;
            end
        end else begin
            o_state = upd;
        end
    end

endmodule

// ===== hw/rtl/ipv4_dotted_quad_parser.sv =====
// Streaming dotted-decimal IPv4 address parser, top level.
// Uses ipv4dq_pkg, ipv4dq_in_reg and ipv4dq_step.
//
// Input channel (i_in_valid / o_in_ready / i_in_word) carries one ASCII byte
// of a buffer per word, with .last set on the buffer's final byte.
// Output channel (o_out_valid / i_out_ready / o_out_word) carries one result
// per address: the packed address and bytes consumed with status 0, or
// status 1 with address and count 0 on a syntax or range error. After a
// result, the remaining bytes of that buffer are dropped.
// An accepted word lands in the input register; the combinational parse step
// then works on it and writes any result into the output register, where it
// appears once the staged word advances; a full result slot can hold it back.
// One word is taken per cycle while the staged word can advance; only a result
// that would go into a full slot that is not being read stalls the flow.
// Reset clears both valid flags and returns the parser to the start of a
// buffer. While the receiver holds i_out_ready low with a result pending,
// bytes that give no result keep flowing; a byte that would give a second
// result waits in the input register, and then the input channel stalls.
module ipv4_dotted_quad_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ipv4dq_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ipv4dq_pkg::t_out_word o_out_word
);

    logic                     stg_valid;
    ipv4dq_pkg::t_in_word     stg_word;
    logic                     advance;
    logic                     emit;
    ipv4dq_pkg::t_parse_state n_state;
    ipv4dq_pkg::t_out_word    result;

    ipv4dq_pkg::t_parse_state r_state;
    logic                     r_out_valid;
    ipv4dq_pkg::t_out_word    r_out_word;

    ipv4dq_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (stg_valid),
        .i_take  (advance),
        .o_word  (stg_word)
    );

    ipv4dq_step u_step (
        .i_state  (r_state),
        .i_word   (stg_word),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_result (result)
    );

    // hold the staged word only if it would produce a result into a full slot that is not being read
    assign advance = stg_valid && (!emit || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipv4dq_pkg::PARSE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ipv4dq_pkg::ST_ERR))
        |-> (o_out_word.address == 32'd0) && (o_out_word.consumed == 4'd0))
        else $error("error result carries nonzero address or count");

    a_ok_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ipv4dq_pkg::ST_OK))
        |-> (o_out_word.consumed >= 4'd7))
        else $error("successful result shorter than a minimal address");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state.phase == ipv4dq_pkg::PH_START)
                     && (r_state.byte_count == 4'd0) && !r_out_valid)
        else $error("parse state not cleared by reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result slot");

endmodule

// ===== test/tb.sv =====
// Testbench for ipv4_dotted_quad_parser: directed table, then random buffers, each
// result checked against the table's expected word or an in-bench parse of the same bytes.
// Depends on ipv4dq_pkg and the parser RTL only.
module tb;

    typedef enum int {
        PACE_RECV_SLOW,
        PACE_SEND_SLOW,
        PACE_FREE
    } t_pace;

    typedef enum int {
        FLAW_NONE,
        FLAW_LEAD,
        FLAW_BIG,
        FLAW_WIDE,
        FLAW_CHAR,
        FLAW_CUT,
        FLAW_TERM
    } t_flaw;

    typedef struct packed {
        logic [7:0]            ch;
        logic                  last;
        logic                  typed;
        ipv4dq_pkg::t_out_word want;
    } t_dir_row;

    localparam int RANDOM_WORDS = 900;
    localparam int NUM_DIR_ROWS = 32;

    localparam ipv4dq_pkg::t_out_word NO_ADDR  =
        '{address: 32'd0, consumed: 4'd0, status: ipv4dq_pkg::ST_ERR};
    localparam ipv4dq_pkg::t_out_word ALL_ONES =
        '{address: 32'hFFFF_FFFF, consumed: 4'd15, status: ipv4dq_pkg::ST_OK};
    localparam ipv4dq_pkg::t_out_word UNTYPED  = '0;

    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        // widest address, closed by a NUL on the last byte
        '{"2", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED},
        '{ipv4dq_pkg::CH_DOT, 1'b0, 1'b0, UNTYPED},
        '{"2", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED},
        '{ipv4dq_pkg::CH_DOT, 1'b0, 1'b0, UNTYPED},
        '{"2", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED},
        '{ipv4dq_pkg::CH_DOT, 1'b0, 1'b0, UNTYPED},
        '{"2", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED}, '{"5", 1'b0, 1'b0, UNTYPED},
        '{ipv4dq_pkg::CH_NUL, 1'b1, 1'b1, ALL_ONES},
        // non-digit where an octet starts
        '{8'hFF, 1'b1, 1'b1, NO_ADDR},
        // digit after a leading zero
        '{"0", 1'b0, 1'b0, UNTYPED}, '{"7", 1'b1, 1'b1, NO_ADDR},
        // fourth digit
        '{"1", 1'b0, 1'b0, UNTYPED}, '{"0", 1'b0, 1'b0, UNTYPED}, '{"0", 1'b0, 1'b0, UNTYPED},
        '{"0", 1'b1, 1'b1, NO_ADDR},
        // octet above 255, then drop the rest of the buffer
        '{"3", 1'b0, 1'b0, UNTYPED}, '{"0", 1'b0, 1'b0, UNTYPED}, '{"0", 1'b0, 1'b1, NO_ADDR},
        '{ipv4dq_pkg::CH_DOT, 1'b1, 1'b0, UNTYPED},
        // wrong separator
        '{"9", 1'b0, 1'b0, UNTYPED}, '{",", 1'b1, 1'b1, NO_ADDR},
        // buffer ends after a dot
        '{"5", 1'b0, 1'b0, UNTYPED}, '{ipv4dq_pkg::CH_DOT, 1'b1, 1'b1, NO_ADDR},
        // buffer ends inside the first octet
        '{"4", 1'b1, 1'b1, NO_ADDR}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    ipv4dq_pkg::t_in_word  in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ipv4dq_pkg::t_out_word out_word;

    t_pace                 pace       = PACE_RECV_SLOW;
    int                    mismatches = 0;
    int                    sent_words = 0;
    ipv4dq_pkg::t_out_word addr_due [$];
    ipv4dq_pkg::t_out_word due_word;
    logic [7:0]            chars [$];

    // shadow parse state
    ipv4dq_pkg::t_phase ps_phase;
    logic [1:0]         ps_octet_idx;
    logic [7:0]         ps_octet_val;
    logic [1:0]         ps_digits;
    logic               ps_lead_zero;
    logic [23:0]        ps_done_octets;
    logic [3:0]         ps_count;

    ipv4_dotted_quad_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #5 clk = ~clk;

    function automatic int send_gap_pct();
        case (pace)
            PACE_RECV_SLOW: return 21;
            PACE_SEND_SLOW: return 72;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (pace)
            PACE_RECV_SLOW: return 72;
            PACE_SEND_SLOW: return 21;
            default:        return 0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= ipv4dq_pkg::CH_ZERO && c <= ipv4dq_pkg::CH_NINE;
    endfunction

    task automatic clear_parse();
        ps_phase       = ipv4dq_pkg::PH_START;
        ps_octet_idx   = 2'd0;
        ps_octet_val   = 8'd0;
        ps_digits      = 2'd0;
        ps_lead_zero   = 1'b0;
        ps_done_octets = 24'd0;
        ps_count       = 4'd0;
    endtask

    task automatic emit_result(input logic ok, input logic is_last,
                               output ipv4dq_pkg::t_out_word res);
        if (ok)
            res = '{address: {ps_done_octets, ps_octet_val}, consumed: ps_count,
                    status: ipv4dq_pkg::ST_OK};
        else
            res = NO_ADDR;
        clear_parse();
        // drop what is left of the buffer unless this byte closed it
        if (!is_last)
            ps_phase = ipv4dq_pkg::PH_DRAIN;
    endtask

    task automatic parse_char(input ipv4dq_pkg::t_in_word w, output logic got,
                              output ipv4dq_pkg::t_out_word res);
        logic [11:0] acc;
        got = 1'b0;
        res = '0;
        case (ps_phase)
            ipv4dq_pkg::PH_START: begin
                if (!is_digit(w.byte_in)) begin
                    emit_result(1'b0, w.last, res);
                    got = 1'b1;
                end else begin
                    ps_octet_val = w.byte_in - ipv4dq_pkg::CH_ZERO;
                    ps_digits    = 2'd1;
                    ps_lead_zero = (w.byte_in == ipv4dq_pkg::CH_ZERO);
                    ps_count     = ps_count + 4'd1;
                    ps_phase     = ipv4dq_pkg::PH_DIGITS;
                    if (w.last) begin
                        emit_result(ps_octet_idx == ipv4dq_pkg::LAST_OCTET, 1'b1, res);
                        got = 1'b1;
                    end
                end
            end
            ipv4dq_pkg::PH_DIGITS: begin
                if (is_digit(w.byte_in)) begin
                    acc = 12'(ps_octet_val) * 12'd10 + 12'(w.byte_in)
                        - 12'(ipv4dq_pkg::CH_ZERO);
                    if (ps_lead_zero || ps_digits >= ipv4dq_pkg::MAX_DIGITS
                        || acc > ipv4dq_pkg::OCTET_MAX) begin
                        emit_result(1'b0, w.last, res);
                        got = 1'b1;
                    end else begin
                        ps_octet_val = acc[7:0];
                        ps_digits    = ps_digits + 2'd1;
                        ps_count     = ps_count + 4'd1;
                        if (w.last) begin
                            emit_result(ps_octet_idx == ipv4dq_pkg::LAST_OCTET, 1'b1, res);
                            got = 1'b1;
                        end
                    end
                end else if (ps_octet_idx != ipv4dq_pkg::LAST_OCTET) begin
                    if (w.byte_in != ipv4dq_pkg::CH_DOT) begin
                        emit_result(1'b0, w.last, res);
                        got = 1'b1;
                    end else begin
                        ps_done_octets = {ps_done_octets[15:0], ps_octet_val};
                        ps_octet_val   = 8'd0;
                        ps_digits      = 2'd0;
                        ps_lead_zero   = 1'b0;
                        ps_octet_idx   = ps_octet_idx + 2'd1;
                        ps_count       = ps_count + 4'd1;
                        ps_phase       = ipv4dq_pkg::PH_START;
                        if (w.last) begin
                            emit_result(1'b0, 1'b1, res);
                            got = 1'b1;
                        end
                    end
                end else begin
                    emit_result(w.byte_in == ipv4dq_pkg::CH_SPACE
                                || w.byte_in == ipv4dq_pkg::CH_NUL, w.last, res);
                    got = 1'b1;
                end
            end
            default: begin
                if (w.last)
                    clear_parse();
            end
        endcase
    endtask

    task automatic push_word(input ipv4dq_pkg::t_in_word w, input logic typed,
                             input ipv4dq_pkg::t_out_word want);
        logic                  got;
        ipv4dq_pkg::t_out_word res;
        while ($urandom_range(0, 99) < send_gap_pct()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sent_words++;
        parse_char(w, got, res);
        if (typed)
            addr_due.push_back(want);
        else if (got)
            addr_due.push_back(res);
    endtask

    function automatic int pick_octet();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 0;
        if (roll < 30) return 255;
        if (roll < 55) return $urandom_range(0, 9);
        if (roll < 75) return $urandom_range(10, 99);
        return $urandom_range(100, 255);
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 3))
            0:       return ipv4dq_pkg::CH_DOT;
            1:       return ipv4dq_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic append_number(input int v);
        if (v >= 1000) chars.push_back(ipv4dq_pkg::CH_ZERO + 8'(v / 1000));
        if (v >= 100)  chars.push_back(ipv4dq_pkg::CH_ZERO + 8'((v / 100) % 10));
        if (v >= 10)   chars.push_back(ipv4dq_pkg::CH_ZERO + 8'((v / 10) % 10));
        chars.push_back(ipv4dq_pkg::CH_ZERO + 8'(v % 10));
    endtask

    task automatic send_buffer();
        int                   roll;
        int                   slot;
        int                   cut;
        t_flaw                flaw;
        logic [7:0]           junk;
        ipv4dq_pkg::t_in_word w;
        chars.delete();
        roll = $urandom_range(0, 99);
        if (roll >= 85) begin
            repeat ($urandom_range(1, 6)) chars.push_back(noise_char());
        end else begin
            flaw = (roll < 60) ? FLAW_NONE
                               : t_flaw'($urandom_range(int'(FLAW_LEAD), int'(FLAW_TERM)));
            slot = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) begin
                if (i != 0)
                    chars.push_back(ipv4dq_pkg::CH_DOT);
                if (i == slot && flaw == FLAW_LEAD) begin
                    chars.push_back(ipv4dq_pkg::CH_ZERO);
                    append_number(pick_octet());
                end else if (i == slot && flaw == FLAW_BIG) begin
                    append_number($urandom_range(256, 999));
                end else if (i == slot && flaw == FLAW_WIDE) begin
                    append_number($urandom_range(1000, 9999));
                end else begin
                    append_number(pick_octet());
                end
            end
            if (flaw == FLAW_CHAR)
                chars[$urandom_range(0, chars.size() - 1)] = noise_char();
            if (flaw == FLAW_CUT) begin
                cut = $urandom_range(1, chars.size() - 1);
                while (chars.size() > cut)
                    chars.delete(chars.size() - 1);
            end else begin
                if (flaw == FLAW_TERM) begin
                    do junk = noise_char();
                    while (junk == ipv4dq_pkg::CH_SPACE || junk == ipv4dq_pkg::CH_NUL);
                    chars.push_back(junk);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       ;
                        1:       chars.push_back(ipv4dq_pkg::CH_SPACE);
                        default: chars.push_back(ipv4dq_pkg::CH_NUL);
                    endcase
                end
                // trailing bytes after a terminator or a bad terminator get dropped
                if (chars[chars.size() - 1] == ipv4dq_pkg::CH_SPACE ||
                    chars[chars.size() - 1] == ipv4dq_pkg::CH_NUL ||
                    flaw == FLAW_TERM)
                    repeat ($urandom_range(0, 3)) chars.push_back(noise_char());
            end
        end
        foreach (chars[j]) begin
            w.byte_in = chars[j];
            w.last    = (j == chars.size() - 1);
            push_word(w, 1'b0, UNTYPED);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (addr_due.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual %h",
                         $time, out_word);
                mismatches++;
            end else begin
                due_word = addr_due.pop_front();
                if (out_word.address !== due_word.address) begin
                    $display("%0t: address expected %h actual %h",
                             $time, due_word.address, out_word.address);
                    mismatches++;
                end
                if (out_word.consumed !== due_word.consumed) begin
                    $display("%0t: consumed expected %0d actual %0d",
                             $time, due_word.consumed, out_word.consumed);
                    mismatches++;
                end
                if (out_word.status !== due_word.status) begin
                    $display("%0t: status expected %b actual %b",
                             $time, due_word.status, out_word.status);
                    mismatches++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end

    initial begin
        int settle;
        clear_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < NUM_DIR_ROWS; k++)
            push_word(ipv4dq_pkg::t_in_word'{byte_in: DIR_ROWS[k].ch, last: DIR_ROWS[k].last},
                      DIR_ROWS[k].typed, DIR_ROWS[k].want);
        while (sent_words < NUM_DIR_ROWS + RANDOM_WORDS) begin
            if (sent_words < NUM_DIR_ROWS + RANDOM_WORDS / 3)
                pace = PACE_RECV_SLOW;
            else if (sent_words < NUM_DIR_ROWS + 2 * RANDOM_WORDS / 3)
                pace = PACE_SEND_SLOW;
            else
                pace = PACE_FREE;
            send_buffer();
        end
        in_valid <= 1'b0;
        settle = 0;
        while (addr_due.size() != 0 && settle < 5000) begin
            @(posedge clk);
            settle++;
        end
        if (addr_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, addr_due.size());
            $display("tb: errors");
        end else begin
            // catch any stray result after the last expected one
            repeat (10) @(posedge clk);
            if (mismatches == 0)
                $display("tb: clean");
            else
                $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("tb: errors");
        $finish;
    end

endmodule
